/* rtl/core/mar_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the memory access request handler.
// No dependencies.
package mar_pkg;

	localparam logic [7:0] VERSION_CODE   = 8'h10;
	localparam logic [7:0] GEN_POLY       = 8'hC5;
	localparam logic [7:0] CRC_INIT       = 8'hFF;
	localparam logic [7:0] CHECK_MASK     = 8'hE7;
	localparam logic [7:0] AUTOINC_ENABLE = 8'h01;

	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_DROP  = 2'd3;

	localparam logic [2:0] RESP_EMPTY = 3'd0;
	localparam logic [2:0] RESP_DATA  = 3'd1;
	localparam logic [2:0] RESP_BAD   = 3'd2;

	localparam logic [2:0] REQ_VERSION = 3'd0;
	localparam logic [2:0] REQ_FLAGS   = 3'd1;
	localparam logic [2:0] REQ_ADDR    = 3'd2;
	localparam logic [2:0] REQ_READ    = 3'd3;
	localparam logic [2:0] REQ_WRITE   = 3'd4;

	typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_REPLY} phase_t;
	typedef enum logic [1:0] {PEND_NONE, PEND_READ, PEND_WRITE} pend_t;

	// one CRC-8 byte step, MSB first
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] b;
		logic       top;
		c = crc;
		b = data;
		for (int i = 0; i < 8; i++) begin
			top = c[7];
			c = {c[6:0], b[7]};
			b = {b[6:0], 1'b0};
			if (top) begin
				c = c ^ GEN_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic odd3(input logic [2:0] v);
		return ^v;
	endfunction

	function automatic logic [7:0] make_header(input logic [2:0] rsp, input logic [2:0] size);
		logic [7:0] h;
		h = {rsp, 2'b00, size} & CHECK_MASK;
		h[4] = odd3(rsp);
		h[3] = odd3(size);
		return h;
	endfunction

endpackage

/* rtl/core/memory_access_request_handler_core.sv */
`timescale 1ns / 1ps
// Device side of a byte-framed memory access link: frame check, request decode, response send.
// Depends on mar_pkg.
//
// Input channel (in_valid / in_stall): one word is either a link byte (action 0)
// or a memory reply (action 1, reply_ok, reply_data).
// Output channel (out_valid / out_stall): one word is a transmit byte, a memory
// read or write request, or a frame-dropped report; last marks the final word
// caused by an input word.
// Results: a word that causes a single result (drop, memory request) shows it
// in the output register in the cycle after acceptance. A response frame starts
// once the sequencer has entered its send state and loaded the header into the
// output register, then goes out one byte per cycle while the receiver does not
// stall: header, 1 to 8 data bytes and CRC, so 3 to 10 bytes.
// Flow: one input word at a time. in_stall is high while a response frame is
// being sent or a result sits in the output register, so no new word is taken
// before the last is through; the byte sequencer runs around the single shared CRC byte unit.
// The shared CRC unit checks received frames while idle and builds the
// response CRC while sending.
// Reset: phase waits for a header, no access pending, address and auto-increment
// cleared, output register empty.
// Receiver stall: the output register holds its word and the sequencer waits.
module memory_access_request_handler_core
	import mar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  link_byte,
	input  logic        reply_ok,
	input  logic [63:0] reply_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic [63:0] mem_address,
	output logic [63:0] write_data,
	output logic [3:0]  byte_count,
	output logic        last
);

	typedef enum logic {ST_IDLE, ST_SEND} state_t;

	state_t      state_q;
	phase_t      phase_q;
	pend_t       pend_q;
	logic [7:0]  header_q;
	logic [3:0]  seen_q;
	logic [7:0]  frame_q [8];
	logic [7:0]  crc_q;
	logic [63:0] addr_q;
	logic        autoinc_q;
	logic [3:0]  cnt_q;

	// response frame sequencer
	logic [2:0]  rsp_q;
	logic [2:0]  size_q;
	logic [63:0] txdata_q;
	logic [3:0]  idx_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_q;
	logic [63:0] maddr_q;
	logic [63:0] wdata_q;
	logic [3:0]  bcnt_q;
	logic        last_q;

	logic        accept;
	logic        out_free;
	logic [3:0]  last_idx;
	logic [2:0]  data_sel;
	logic [7:0]  tx_pre;
	logic [7:0]  crc_base;
	logic [7:0]  crc_in;
	logic [7:0]  crc_out;
	logic [2:0]  hreq;
	logic [2:0]  hsize;
	logic        body_done;
	logic [63:0] addr_be;
	logic [63:0] wd_asm;
	logic [3:0]  size_x;

	// request decode at the end of a good frame
	logic        frame_ok;
	logic        issue_now;
	logic        flags_hit;
	logic        addr_hit;
	logic [2:0]  dec_rsp;
	logic [63:0] dec_txdata;
	logic        dec_issue;
	logic [1:0]  dec_kind;
	logic [63:0] dec_wdata;
	logic [3:0]  dec_cnt;
	pend_t       dec_pend;

	// response to a memory reply
	logic [2:0]  rep_rsp;
	logic [2:0]  rep_size;
	logic [63:0] rep_txdata;

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign last_idx = {1'b0, size_q} + 4'd2;
	assign data_sel = 3'(idx_q - 4'd1);
	assign hreq     = header_q[7:5];
	assign hsize    = header_q[2:0];
	assign size_x   = {1'b0, hsize};
	assign body_done = seen_q > size_x;

	always_comb begin
		if (idx_q == 4'd0) begin
			tx_pre = make_header(rsp_q, size_q);
		end else begin
			tx_pre = txdata_q[{data_sel, 3'b000} +: 8];
		end
	end

	// shared CRC byte unit: receive check while idle, response CRC while sending
	always_comb begin
		if (state_q == ST_SEND) begin
			crc_base = crc_q;
			crc_in   = (idx_q == last_idx) ? 8'h00 : tx_pre;
		end else if (phase_q == PH_HEADER) begin
			crc_base = CRC_INIT;
			crc_in   = link_byte;
		end else begin
			crc_base = crc_q;
			crc_in   = body_done ? 8'h00 : link_byte;
		end
	end
	assign crc_out = crc_feed(crc_base, crc_in);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			addr_be[8*(7-i) +: 8] = frame_q[i];
			wd_asm[8*i +: 8]      = (4'(i) <= size_x) ? frame_q[i] : 8'h00;
		end
	end

	assign frame_ok  = !action && phase_q == PH_BODY && body_done && crc_out == link_byte;
	assign issue_now = frame_ok && dec_issue;
	assign flags_hit = hreq == REQ_FLAGS && hsize == 3'd0;
	assign addr_hit  = hreq == REQ_ADDR && hsize == 3'd7;

	// decode the request; anything not matched answers invalid
	always_comb begin
		dec_rsp    = RESP_BAD;
		dec_txdata = {56'd0, frame_q[0]};
		dec_issue  = 1'b0;
		dec_kind   = KIND_DROP;
		dec_wdata  = '0;
		dec_cnt    = '0;
		dec_pend   = PEND_NONE;
		priority if (hreq == REQ_VERSION && hsize == 3'd0 && frame_q[0] == 8'h00) begin
			dec_rsp    = RESP_DATA;
			dec_txdata = {56'd0, VERSION_CODE};
		end else if (flags_hit && frame_q[0] == AUTOINC_ENABLE) begin
			dec_rsp = RESP_EMPTY;
		end else if (addr_hit) begin
			dec_rsp = RESP_EMPTY;
		end else if (hreq == REQ_READ && hsize == 3'd0 && frame_q[0] < 8'd8) begin
			dec_issue = 1'b1;
			dec_kind  = KIND_READ;
			dec_cnt   = frame_q[0][3:0] + 4'd1;
			dec_pend  = PEND_READ;
		end else if (hreq == REQ_WRITE) begin
			dec_issue = 1'b1;
			dec_kind  = KIND_WRITE;
			dec_wdata = wd_asm;
			dec_cnt   = size_x + 4'd1;
			dec_pend  = PEND_WRITE;
		end else begin
			dec_issue = 1'b0;
		end
	end

	// failed access answers invalid and echoes the first frame byte
	always_comb begin
		rep_rsp    = RESP_BAD;
		rep_size   = '0;
		rep_txdata = {56'd0, frame_q[0]};
		if (reply_ok) begin
			if (pend_q == PEND_READ) begin
				rep_rsp    = RESP_DATA;
				rep_size   = 3'(cnt_q - 4'd1);
				rep_txdata = reply_data;
			end else begin
				rep_rsp = RESP_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_HEADER;
			pend_q      <= PEND_NONE;
			header_q    <= '0;
			seen_q      <= '0;
			crc_q       <= CRC_INIT;
			addr_q      <= '0;
			autoinc_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			rsp_q       <= '0;
			size_q      <= '0;
			idx_q       <= '0;
		end else begin
			// while sending, the sequencer reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_SEND) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q   <= issue_now ? dec_kind : KIND_DROP;
						tx_q     <= 8'h00;
						maddr_q  <= issue_now ? addr_q : '0;
						wdata_q  <= issue_now ? dec_wdata : '0;
						bcnt_q   <= issue_now ? dec_cnt : '0;
						last_q   <= 1'b1;
						idx_q    <= '0;
						rsp_q    <= action ? rep_rsp : dec_rsp;
						size_q   <= action ? rep_size : 3'd0;
						txdata_q <= action ? rep_txdata : dec_txdata;
						if (!action) begin
							unique case (phase_q)
								PH_HEADER: begin
									if (link_byte[4] != odd3(link_byte[7:5]) ||
									    link_byte[3] != odd3(link_byte[2:0])) begin
										out_valid_q <= 1'b1;
									end else begin
										header_q <= link_byte;
										seen_q   <= '0;
										crc_q    <= crc_out;
										phase_q  <= PH_BODY;
									end
								end
								PH_BODY: begin
									if (!body_done) begin
										frame_q[seen_q[2:0]] <= link_byte;
										crc_q  <= crc_out;
										seen_q <= seen_q + 4'd1;
									end else begin
										seen_q <= '0;
										crc_q  <= CRC_INIT;
										if (!frame_ok) begin
											phase_q     <= PH_HEADER;
											out_valid_q <= 1'b1;
										end else if (dec_issue) begin
											// memory request, wait for the reply
											phase_q     <= PH_REPLY;
											pend_q      <= dec_pend;
											cnt_q       <= dec_cnt;
											out_valid_q <= 1'b1;
										end else begin
											phase_q <= PH_HEADER;
											state_q <= ST_SEND;
											if (flags_hit) begin
												autoinc_q <= frame_q[0] == AUTOINC_ENABLE;
											end
											if (addr_hit) begin
												addr_q <= addr_be;
											end
										end
									end
								end
								default: begin
								end
							endcase
						end else if (phase_q == PH_REPLY && pend_q != PEND_NONE) begin
							phase_q <= PH_HEADER;
							pend_q  <= PEND_NONE;
							state_q <= ST_SEND;
							if (reply_ok && autoinc_q) begin
								addr_q <= addr_q + {60'd0, cnt_q};
							end
						end
					end
				end
				ST_SEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q  <= KIND_TX;
						maddr_q <= '0;
						wdata_q <= '0;
						bcnt_q  <= '0;
						if (idx_q == last_idx) begin
							tx_q    <= crc_out;
							last_q  <= 1'b1;
							crc_q   <= CRC_INIT;
							state_q <= ST_IDLE;
						end else begin
							tx_q   <= tx_pre;
							last_q <= 1'b0;
							crc_q  <= crc_out;
							idx_q  <= idx_q + 4'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign tx_byte     = tx_q;
	assign mem_address = maddr_q;
	assign write_data  = wdata_q;
	assign byte_count  = bcnt_q;
	assign last        = last_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench for memory_access_request_handler_core: frames, memory replies and response frames.
// Depends on mar_pkg and the core; predicts every output word and checks each one in order.
module testbench;
	import mar_pkg::*;

	// one output word as the handler should present it
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [63:0] mem_address;
		logic [63:0] write_data;
		logic [3:0]  byte_count;
		logic        last;
	} out_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  link_byte;
	logic        reply_ok;
	logic [63:0] reply_data;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic [63:0] mem_address;
	logic [63:0] write_data;
	logic [3:0]  byte_count;
	logic        last;

	memory_access_request_handler_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .link_byte(link_byte), .reply_ok(reply_ok), .reply_data(reply_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .tx_byte(tx_byte), .mem_address(mem_address),
		.write_data(write_data), .byte_count(byte_count), .last(last)
	);

	localparam int WATCHDOG_LIMIT = 4000;

	// handler state as predicted
	phase_t      m_phase;
	pend_t       m_pend;
	logic [7:0]  m_header;
	logic [3:0]  m_seen;
	logic [7:0]  m_data [8];
	logic [7:0]  m_crc;
	logic [63:0] m_addr;
	logic        m_autoinc;
	logic [3:0]  m_count;

	out_word_t   expected_words [$];
	int          error_count;
	int          words_sent;
	int          words_checked;
	int          drops_seen;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_idle_pct;

	initial begin
		clk = 1'b0;
	end
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h want %0h (word %0d)", what, got, want, words_checked);
		error_count++;
	endtask

	// prediction -------------------------------------------------------

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] d;
		logic       msb;
		c = crc;
		d = b;
		for (int i = 0; i < 8; i++) begin
			msb = c[7];
			c = {c[6:0], d[7]};
			d = d << 1;
			if (msb) begin
				c = c ^ 8'hC5;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] frame_header(input logic [2:0] rsp, input logic [2:0] sz);
		return {rsp, ^rsp, ^sz, sz};
	endfunction

	task automatic push_word(input logic [1:0] k, input logic [7:0] tx, input logic [63:0] a,
			input logic [63:0] wd, input logic [3:0] cnt);
		out_word_t w;
		w = '{k, tx, a, wd, cnt, 1'b0};
		expected_words.push_back(w);
	endtask

	task automatic push_response(input logic [2:0] rsp, input logic [2:0] sz,
			input logic [7:0] body [8]);
		logic [7:0] crc;
		logic [7:0] h;
		h = frame_header(rsp, sz);
		push_word(KIND_TX, h, '0, '0, '0);
		crc = crc_step(CRC_INIT, h);
		for (int i = 0; i <= sz; i++) begin
			push_word(KIND_TX, body[i], '0, '0, '0);
			crc = crc_step(crc, body[i]);
		end
		push_word(KIND_TX, crc_step(crc, 8'h00), '0, '0, '0);
	endtask

	task automatic decode_request();
		logic [2:0]  req;
		logic [2:0]  sz;
		logic [7:0]  body [8];
		logic [63:0] wd;
		req = m_header[7:5];
		sz = m_header[2:0];
		body = m_data;
		if (req == REQ_VERSION && sz == 0 && m_data[0] == 8'h00) begin
			body[0] = VERSION_CODE;
			push_response(RESP_DATA, 3'd0, body);
			return;
		end
		if (req == REQ_FLAGS && sz == 0) begin
			m_autoinc = 1'b0;
			if (m_data[0] == AUTOINC_ENABLE) begin
				m_autoinc = 1'b1;
				push_response(RESP_EMPTY, 3'd0, body);
				return;
			end
		end
		if (req == REQ_ADDR && sz == 7) begin
			for (int i = 0; i < 8; i++) begin
				m_addr[63 - 8*i -: 8] = m_data[i];
			end
			push_response(RESP_EMPTY, 3'd0, body);
			return;
		end
		if (req == REQ_READ && sz == 0 && m_data[0] < 8) begin
			m_count = m_data[0][3:0] + 4'd1;
			m_pend = PEND_READ;
			m_phase = PH_REPLY;
			push_word(KIND_READ, '0, m_addr, '0, m_count);
			return;
		end
		if (req == REQ_WRITE) begin
			wd = '0;
			for (int i = 0; i <= sz; i++) begin
				wd[8*i +: 8] = m_data[i];
			end
			m_count = {1'b0, sz} + 4'd1;
			m_pend = PEND_WRITE;
			m_phase = PH_REPLY;
			push_word(KIND_WRITE, '0, m_addr, wd, m_count);
			return;
		end
		push_response(RESP_BAD, 3'd0, body);
	endtask

	// advance the predicted state by one accepted input word
	task automatic predict_word(input logic act, input logic [7:0] b, input logic ok,
			input logic [63:0] rd);
		int         n_prior;
		logic [7:0] fin;
		logic [7:0] body [8];
		n_prior = expected_words.size();
		if (!act) begin
			if (m_phase == PH_HEADER) begin
				if (b[4] != ^b[7:5] || b[3] != ^b[2:0]) begin
					push_word(KIND_DROP, '0, '0, '0, '0);
				end else begin
					m_header = b;
					m_seen = '0;
					m_crc = crc_step(CRC_INIT, b);
					m_phase = PH_BODY;
				end
			end else if (m_phase == PH_BODY) begin
				if (m_seen <= m_header[2:0]) begin
					m_data[m_seen[2:0]] = b;
					m_crc = crc_step(m_crc, b);
					m_seen++;
				end else begin
					fin = crc_step(m_crc, 8'h00);
					m_phase = PH_HEADER;
					m_seen = '0;
					m_crc = CRC_INIT;
					if (fin != b) begin
						push_word(KIND_DROP, '0, '0, '0, '0);
					end else begin
						decode_request();
					end
				end
			end
		end else if (m_phase == PH_REPLY && m_pend != PEND_NONE) begin
			m_phase = PH_HEADER;
			if (!ok) begin
				push_response(RESP_BAD, 3'd0, m_data);
			end else begin
				if (m_autoinc) begin
					m_addr = m_addr + {60'd0, m_count};
				end
				if (m_pend == PEND_READ) begin
					for (int i = 0; i < 8; i++) begin
						body[i] = rd[8*i +: 8];
					end
					push_response(RESP_DATA, m_count[2:0] - 3'd1, body);
				end else begin
					push_response(RESP_EMPTY, 3'd0, m_data);
				end
			end
			m_pend = PEND_NONE;
		end
		if (expected_words.size() > n_prior) begin
			expected_words[$].last = 1'b1;
		end
	endtask

	// stimulus ----------------------------------------------------------

	// valid stays high after acceptance; the next word or an idle cycle replaces it
	task automatic send_word(input logic act, input logic [7:0] b, input logic ok,
			input logic [63:0] rd);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) begin
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		action <= act;
		link_byte <= b;
		reply_ok <= ok;
		reply_data <= rd;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_word(act, b, ok, rd);
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(1'b0, b, 1'($urandom_range(1)), {$urandom, $urandom});
	endtask

	task automatic send_reply(input logic ok, input logic [63:0] rd);
		send_word(1'b1, 8'($urandom_range(255)), ok, rd);
	endtask

	// a well formed frame; corrupt_crc flips bits of the CRC byte
	task automatic send_frame_to_dut(input logic [2:0] req, input logic [2:0] sz,
			input logic [7:0] body [8], input logic [7:0] corrupt_crc);
		logic [7:0] h;
		logic [7:0] crc;
		h = frame_header(req, sz);
		send_byte(h);
		crc = crc_step(CRC_INIT, h);
		for (int i = 0; i <= sz; i++) begin
			send_byte(body[i]);
			crc = crc_step(crc, body[i]);
		end
		send_byte(crc_step(crc, 8'h00) ^ corrupt_crc);
	endtask

	task automatic send_single(input logic [2:0] req, input logic [7:0] b0);
		logic [7:0] body [8];
		body = '{default: 8'h00};
		body[0] = b0;
		send_frame_to_dut(req, 3'd0, body, 8'h00);
	endtask

	task automatic send_address(input logic [63:0] a);
		logic [7:0] body [8];
		for (int i = 0; i < 8; i++) begin
			body[i] = a[63 - 8*i -: 8];
		end
		send_frame_to_dut(REQ_ADDR, 3'd7, body, 8'h00);
	endtask

	task automatic drain_expected();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_directed();
		logic [7:0] body [8];
		send_single(REQ_VERSION, 8'h00);           // version query
		send_single(REQ_VERSION, 8'h01);           // malformed query
		send_byte(8'hE0);                          // header with bad request parity
		send_byte(8'h08);                          // header with bad size parity
		send_address(64'hFFFF_FFFF_FFFF_FFFC);
		send_single(REQ_FLAGS, AUTOINC_ENABLE);
		send_single(REQ_READ, 8'h07);              // eight bytes, wraps address
		send_reply(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		body = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
		send_frame_to_dut(REQ_WRITE, 3'd7, body, 8'h00);
		send_byte(8'h33);                          // link byte while pending, ignored
		send_reply(1'b0, 64'h0);                   // failed access
		send_reply(1'b1, 64'h0);                   // reply with nothing pending
		send_single(REQ_READ, 8'h08);              // read count out of range
		send_single(REQ_FLAGS, 8'h02);             // clears auto-increment
		send_frame_to_dut(REQ_ADDR, 3'd3, body, 8'h00);
		send_single(3'd6, 8'hC3);                  // unknown request
		send_frame_to_dut(REQ_WRITE, 3'd0, body, 8'h01);  // CRC error
	endtask

	task automatic test_random(input int n_items);
		logic [7:0] body [8];
		logic [2:0] req;
		logic [2:0] sz;
		int         pick;
		while (n_items > 0) begin
			pick = $urandom_range(99);
			for (int i = 0; i < 8; i++) begin
				body[i] = 8'($urandom);
			end
			req = 3'($urandom_range(7));
			sz = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1));
			if (req == REQ_READ || req == REQ_FLAGS || req == REQ_VERSION) begin
				if ($urandom_range(3) != 0) begin
					sz = 3'd0;
					body[0] = 8'($urandom_range(req == REQ_READ ? 9 : 2));
				end
			end
			if (pick < 80) begin
				send_frame_to_dut(req, sz, body, (pick < 8) ? 8'($urandom_range(1, 255)) : 8'h00);
				n_items -= sz + 3;
				if (m_phase == PH_REPLY) begin
					send_reply($urandom_range(4) != 0, {$urandom, $urandom});
					n_items--;
				end
			end else if (pick < 90) begin
				send_byte(8'($urandom));
				n_items--;
			end else begin
				send_reply(1'($urandom_range(1)), {$urandom, $urandom});
				n_items--;
			end
		end
		// finish any half frame so the next phase starts clean
		while (m_phase != PH_HEADER) begin
			if (m_phase == PH_REPLY) begin
				send_reply(1'b1, {$urandom, $urandom});
			end else begin
				send_byte(8'($urandom));
			end
		end
	endtask

	task automatic test_pause_drain();
		send_address({$urandom, $urandom});
		drain_expected();                          // sender holds off until all words out
		send_single(REQ_READ, 8'h03);
		send_reply(1'b1, {$urandom, $urandom});
	endtask

	// checking ----------------------------------------------------------

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 64'(kind), 64'd0);
			end else begin
				want = expected_words.pop_front();
				if (kind != want.kind)
					report_mismatch("kind", 64'(kind), 64'(want.kind));
				if (tx_byte != want.tx_byte)
					report_mismatch("tx_byte", 64'(tx_byte), 64'(want.tx_byte));
				if (mem_address != want.mem_address)
					report_mismatch("mem_address", mem_address, want.mem_address);
				if (write_data != want.write_data)
					report_mismatch("write_data", write_data, want.write_data);
				if (byte_count != want.byte_count)
					report_mismatch("byte_count", 64'(byte_count), 64'(want.byte_count));
				if (last != want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
				if (want.kind == KIND_DROP) drops_seen++;
			end
			words_checked++;
		end
	end

	// receiver stall, redrawn every cycle
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress, %0d words still expected",
					expected_words.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		link_byte = 8'h00;
		reply_ok = 1'b0;
		reply_data = '0;
		out_stall = 1'b0;
		error_count = 0;
		words_sent = 0;
		words_checked = 0;
		drops_seen = 0;
		idle_cycles = 0;
		send_idle_pct = 15;
		recv_idle_pct = 60;
		m_phase = PH_HEADER;
		m_pend = PEND_NONE;
		m_header = '0;
		m_seen = '0;
		m_data = '{default: 8'h00};
		m_crc = CRC_INIT;
		m_addr = '0;
		m_autoinc = 1'b0;
		m_count = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(30);
		send_idle_pct = 60;
		recv_idle_pct = 15;
		test_pause_drain();
		test_random(30);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(30);

		drain_expected();
		repeat (20) @(posedge clk);
		$display("Covered %0d input words and %0d output words (%0d dropped frames)",
			words_sent, words_checked, drops_seen);
		$display("including version, flags, address, read, write and error frames");
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
